[rtl/core/mbrd_pkg.sv]
`default_nettype none
package mbrd_pkg;

   localparam int RX_CAPACITY = 32;
   localparam int CNT_W = $clog2(RX_CAPACITY + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] REPLY_BYTE_COUNT = 8'h02;
   localparam logic [15:0] REG_COUNT = 16'h0001;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CRC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

endpackage
`default_nettype wire

[rtl/core/modbus_rtu_read_register_master.sv]
// Modbus RTU master, read of one holding register.
// Input channel req_*: tuser carries the opcode (start, received bus byte,
// timer tick), tdata the slave address, register address and bus byte.
// Result channel rsp_*: a start gives eight request-byte items (tuser bit 0
// set, tlast on the eighth); a transaction end gives one item with tuser
// bit 1 set, bit 2 the status (0 ok, 1 timeout) and the value in tdata.
// Config port csr_*: register 0 at address 0 is the tick timeout.
// A start runs the six leading request bytes through the byte-wide CRC
// unit, then emits one request item per cycle while the receiver takes
// them. An ending result shows the cycle after the ending byte or tick.
// One item is in work at a time; req_tready is high only while no item
// is in work or waiting to be taken.
// When the receiver stalls, the current result item holds and the block
// accepts nothing until it is taken.
// Reset returns to idle with no transaction open and the timeout at 10;
// the request and reply header registers are not cleared.
`default_nettype none
module modbus_rtu_read_register_master
   import mbrd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // slave_address, register_address, rx_byte
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // tx_byte, read_value
   output logic      [2:0]  rsp_tuser,   // tx_valid, done_res, status
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [1:0]       state_ff, state_in;
   logic [2:0]       idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             echo_seen_ff, echo_seen_in;
   logic             mismatch_ff, mismatch_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       ticks_ff, ticks_in;
   logic [7:0]       timeout_ff;
   logic [7:0]       slave_ff, slave_in;
   logic [15:0]      reg_ff, reg_in;
   logic [7:0]       hdr_ff [5];
   logic             hdr_we;
   logic             status_ff, status_in;
   logic [15:0]      value_ff, value_in;

   logic             crc_ctl_init, crc_ctl_step;
   crc_ctl_type      crc_ctl;
   logic [15:0]      crc;
   logic [7:0]       crc_data;

   logic             accept;
   logic [1:0]       opcode;
   logic [7:0]       rx_byte;
   logic [CNT_W-1:0] cnt_inc;
   logic [7:0]       echo_byte;
   logic             mismatch_now;
   logic [7:0]       ticks_inc;
   logic             csr_wr;

   function automatic logic [7:0] req_byte(input logic [2:0] i, input logic [7:0] sa,
                                           input logic [15:0] ra, input logic [15:0] c);
      logic [7:0] r;
      case (i)
         3'd0:    r = sa;
         3'd1:    r = FUNC_READ_HOLDING;
         3'd2:    r = ra[15:8];
         3'd3:    r = ra[7:0];
         3'd4:    r = REG_COUNT[15:8];
         3'd5:    r = REG_COUNT[7:0];
         3'd6:    r = c[7:0];
         default: r = c[15:8];
      endcase
      return r;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign opcode = req_tuser;
   assign rx_byte = req_tdata[31:24];
   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign echo_byte = req_byte(cnt_ff[2:0], slave_ff, reg_ff, crc);
   assign mismatch_now = mismatch_ff || ((cnt_ff < CNT_W'(8)) && (rx_byte != echo_byte));
   assign ticks_inc = (ticks_ff == 8'hFF) ? ticks_ff : ticks_ff + 8'd1;

   assign crc_ctl.init = crc_ctl_init;
   assign crc_ctl.step = crc_ctl_step;
   assign crc_data = req_byte(idx_ff, slave_ff, reg_ff, crc);

   mbrd_crc u_crc (
      .clock     (clock),
      .ctl       (crc_ctl),
      .data_byte (crc_data),
      .crc       (crc)
   );

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      echo_seen_in = echo_seen_ff;
      mismatch_in = mismatch_ff;
      cnt_in = cnt_ff;
      ticks_in = ticks_ff;
      slave_in = slave_ff;
      reg_in = reg_ff;
      hdr_we = 1'b0;
      status_in = status_ff;
      value_in = value_ff;
      crc_ctl_init = 1'b0;
      crc_ctl_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (opcode == OP_START) begin
                  slave_in = req_tdata[7:0];
                  reg_in = req_tdata[23:8];
                  cnt_in = '0;
                  mismatch_in = 1'b0;
                  echo_seen_in = 1'b0;
                  ticks_in = '0;
                  busy_in = 1'b1;
                  idx_in = '0;
                  crc_ctl_init = 1'b1;
                  state_in = ST_CRC;
               end else if (busy_ff && opcode == OP_RX_BYTE &&
                            cnt_ff < CNT_W'(RX_CAPACITY)) begin
                  if (!echo_seen_ff) begin
                     mismatch_in = mismatch_now;
                     cnt_in = cnt_inc;
                     if (cnt_inc == CNT_W'(8) && !mismatch_now) begin
                        echo_seen_in = 1'b1;
                        cnt_in = '0;
                     end
                  end else begin
                     hdr_we = (cnt_ff < CNT_W'(5));
                     cnt_in = cnt_inc;
                     if (cnt_inc >= CNT_W'(7) && hdr_ff[0] == slave_ff &&
                         hdr_ff[1] == FUNC_READ_HOLDING && hdr_ff[2] == REPLY_BYTE_COUNT) begin
                        busy_in = 1'b0;
                        status_in = STATUS_OK;
                        value_in = {hdr_ff[3], hdr_ff[4]};
                        state_in = ST_DONE;
                     end
                  end
               end else if (busy_ff && opcode == OP_TICK) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc >= timeout_ff) begin
                     busy_in = 1'b0;
                     status_in = STATUS_TIMEOUT;
                     value_in = '0;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_CRC: begin
            crc_ctl_step = 1'b1;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd5) begin
               idx_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid = 1'b0;
      rsp_tdata = '0;
      rsp_tuser = '0;
      rsp_tlast = 1'b0;
      case (state_ff)
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tdata = {16'h0000, crc_data};
            rsp_tuser = 3'b001;
            rsp_tlast = (idx_ff == 3'd7);
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            rsp_tdata = {value_ff, 8'h00};
            rsp_tuser = {status_ff, 1'b1, 1'b0};
         end
         default: rsp_tvalid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         busy_ff <= 1'b0;
         echo_seen_ff <= 1'b0;
         mismatch_ff <= 1'b0;
         cnt_ff <= '0;
         ticks_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         busy_ff <= busy_in;
         echo_seen_ff <= echo_seen_in;
         mismatch_ff <= mismatch_in;
         cnt_ff <= cnt_in;
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      slave_ff <= slave_in;
      reg_ff <= reg_in;
      status_ff <= status_in;
      value_ff <= value_in;
      if (hdr_we) begin
         hdr_ff[cnt_ff[2:0]] <= rx_byte;
      end
   end

   // config register
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {24'h000000, timeout_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 8'd10;
      end else if (csr_wr && csr_paddr[2] == 1'b0) begin
         timeout_ff <= csr_pwdata[7:0];
      end
   end

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> !busy_ff)
      else $error("ending item while transaction still open");

   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser[0] && !rsp_tuser[1]))
      else $error("last flag on a non-request item");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RX_CAPACITY))
      else $error("receive count beyond capacity");

   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      echo_seen_ff |-> !mismatch_ff)
      else $error("echo accepted despite mismatch");

   a_emit_after_crc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) != ST_EMIT) |-> $past(state_ff) == ST_CRC)
      else $error("request sent without crc pass");

endmodule
`default_nettype wire

[rtl/core/mbrd_crc.sv]
`default_nettype none
module mbrd_crc
   import mbrd_pkg::*;
(
   input  wire logic        clock,
   input  wire crc_ctl_type ctl,
   input  wire logic [7:0]  data_byte,
   output logic      [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end else if (ctl.step) begin
         crc_in = crc_byte(crc_ff, data_byte);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule
`default_nettype wire

[tb/modbus_rtu_read_register_master_tb.sv]
`default_nettype none
module modbus_rtu_read_register_master_tb;
   import mbrd_pkg::*;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [2:0] TIMEOUT_ADDR = 3'd0;
   localparam int DIR_ROWS = 25;
   localparam int DIR_SPLIT = 21;
   localparam int PHASE_ITEMS = 70;
   localparam logic [7:0] TMO_PLAN [5] = '{8'd255, 8'd0, 8'd10, 8'd3, 8'd0};

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        done;
      logic        status;
      logic [15:0] value;
   } master_out_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  slave;
      logic [15:0] regaddr;
      logic [7:0]  rx;
      logic        echo;
      logic        typed;
      logic        t_end;
      logic        t_status;
      logic [15:0] t_value;
   } dir_row_type;

   // echo rows take the byte from the request in flight
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b1, 1'b0, STATUS_OK, 16'h0000},
      '{OP_UNKNOWN, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 1'b0, STATUS_OK, 16'h0000},
      '{OP_START,   8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_START,   8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_UNKNOWN, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, FUNC_READ_HOLDING, 1'b0, 1'b0, 1'b0, STATUS_OK,
        16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, REPLY_BYTE_COUNT, 1'b0, 1'b0, 1'b0, STATUS_OK,
        16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'hAB, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'hCD, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'hFF, 1'b0, 1'b1, 1'b1, STATUS_OK, 16'hABCD},
      '{OP_START,   8'h5A, 16'hA55A, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_RX_BYTE, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 16'h0000},
      '{OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_TIMEOUT, 16'h0000},
      '{OP_TICK,    8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_OK, 16'h0000}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   logic [31:0] req_tdata = '0;    // slave_address, register_address, rx_byte
   logic [1:0]  req_tuser = OP_TICK; // opcode
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire logic [23:0] rsp_tdata;    // tx_byte, read_value
   wire logic [2:0]  rsp_tuser;    // tx_valid, done_res, status
   wire logic   rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = TIMEOUT_ADDR;
   logic [31:0] csr_pwdata = '0;
   wire logic [31:0] csr_prdata;
   wire logic   csr_pready;

   modbus_rtu_read_register_master u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // master state as the block should hold it
   logic [7:0]  m_tmo = 8'd10;
   logic [7:0]  m_req [8];
   logic [7:0]  m_hdr [5];
   int          m_rcount = 0;
   logic        m_mism = 1'b0;
   logic        m_echoed = 1'b0;
   logic        m_busy = 1'b0;
   logic [7:0]  m_ticks = 8'd0;

   master_out_type step_out [$];
   master_out_type pending_out [$];
   int          fails = 0;
   int          live_items = 0;
   int          burst_left = 0;
   logic        gaps_on = 1'b1;
   logic        stall_on = 1'b1;
   int          stall_left = 0;

   function automatic logic [15:0] request_crc();
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         c = c ^ {8'h00, m_req[i]};
         for (int j = 0; j < 8; j++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void advance_master(input logic [1:0] op, input logic [7:0] s,
                                          input logic [15:0] ra, input logic [7:0] x);
      logic [15:0] crc;
      step_out.delete();
      case (op)
         OP_START: begin
            m_req[0] = s;
            m_req[1] = FUNC_READ_HOLDING;
            m_req[2] = ra[15:8];
            m_req[3] = ra[7:0];
            m_req[4] = REG_COUNT[15:8];
            m_req[5] = REG_COUNT[7:0];
            crc = request_crc();
            m_req[6] = crc[7:0];
            m_req[7] = crc[15:8];
            m_rcount = 0;
            m_mism = 1'b0;
            m_echoed = 1'b0;
            m_ticks = 8'd0;
            m_busy = 1'b1;
            for (int k = 0; k < 8; k++)
               step_out.push_back('{1'b1, m_req[k], k == 7, 1'b0, STATUS_OK, 16'h0000});
         end
         OP_RX_BYTE: begin
            if (m_busy && m_rcount < RX_CAPACITY) begin
               if (!m_echoed) begin
                  if (m_rcount < 8 && x != m_req[m_rcount])
                     m_mism = 1'b1;
                  m_rcount++;
                  if (m_rcount == 8 && !m_mism) begin
                     m_echoed = 1'b1;
                     m_rcount = 0;
                  end
               end else begin
                  if (m_rcount < 5)
                     m_hdr[m_rcount] = x;
                  m_rcount++;
                  if (m_rcount >= 7 && m_hdr[0] == m_req[0] &&
                      m_hdr[1] == FUNC_READ_HOLDING && m_hdr[2] == REPLY_BYTE_COUNT) begin
                     m_busy = 1'b0;
                     step_out.push_back('{1'b0, 8'h00, 1'b0, 1'b1, STATUS_OK,
                                          {m_hdr[3], m_hdr[4]}});
                  end
               end
            end
         end
         OP_TICK: begin
            if (m_busy) begin
               if (m_ticks != 8'hFF)
                  m_ticks++;
               if (m_ticks >= m_tmo) begin
                  m_busy = 1'b0;
                  step_out.push_back('{1'b0, 8'h00, 1'b0, 1'b1, STATUS_TIMEOUT, 16'h0000});
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] pick8();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic drive_item(input logic [1:0] op, input logic [7:0] s,
                             input logic [15:0] ra, input logic [7:0] x);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {x, ra, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] s,
                            input logic [15:0] ra, input logic [7:0] x);
      if (op == OP_START || (m_busy && (op == OP_RX_BYTE || op == OP_TICK)))
         live_items++;
      advance_master(op, s, ra, x);
      foreach (step_out[k])
         pending_out.push_back(step_out[k]);
      drive_item(op, s, ra, x);
   endtask

   task automatic stray_item();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         send_item(OP_TICK, pick8(), pick16(), pick8());
      else if (r == 1)
         send_item(OP_UNKNOWN, pick8(), pick16(), pick8());
   endtask

   task automatic run_transaction();
      logic [7:0] s;
      logic [7:0] b;
      logic [7:0] frame [7];
      int echo_mode;
      int reply_mode;
      int bad_at;
      int n;
      s = pick8();
      send_item(OP_START, s, pick16(), pick8());
      echo_mode = $urandom_range(0, 9);
      if (echo_mode != 0) begin
         bad_at = (echo_mode == 1) ? $urandom_range(0, 7) : 8;
         for (int k = 0; k < 8; k++) begin
            b = m_req[k];
            if (k == bad_at)
               b = b ^ (8'h01 << $urandom_range(0, 7));
            stray_item();
            send_item(OP_RX_BYTE, pick8(), pick16(), b);
         end
      end
      reply_mode = $urandom_range(0, 9);
      frame[0] = s;
      frame[1] = FUNC_READ_HOLDING;
      frame[2] = REPLY_BYTE_COUNT;
      for (int k = 3; k < 7; k++)
         frame[k] = pick8();
      n = 7;
      if (reply_mode == 7) begin
         bad_at = $urandom_range(0, 2);
         frame[bad_at] = frame[bad_at] ^ 8'($urandom_range(1, 255));
         n = $urandom_range(7, 36);
      end else if (reply_mode == 8) begin
         n = $urandom_range(0, 40);
      end else if (reply_mode == 9) begin
         n = 0;
      end
      for (int k = 0; k < n; k++) begin
         stray_item();
         send_item(OP_RX_BYTE, pick8(), pick16(),
                   (k < 7 && reply_mode != 8) ? frame[k] : pick8());
      end
      if (m_tmo <= 8'd12 && $urandom_range(0, 1) == 1)
         n = m_tmo + 1;
      else
         n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++)
         send_item(OP_TICK, pick8(), pick16(), pick8());
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= {24'h000000, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      m_tmo = v;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      master_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            $error("result item with nothing expected");
            fails++;
         end else begin
            want = pending_out.pop_front();
            check_field("tx_valid", 16'(want.tx_valid), 16'(rsp_tuser[0]));
            check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_tdata[7:0]));
            check_field("tx_last", 16'(want.tx_last), 16'(rsp_tlast));
            check_field("done_res", 16'(want.done), 16'(rsp_tuser[1]));
            check_field("status", 16'(want.status), 16'(rsp_tuser[2]));
            check_field("read_value", want.value, rsp_tdata[23:8]);
         end
      end
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      dir_row_type row;
      logic [7:0] x;
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_SPLIT) begin
            settle();
            write_timeout(8'd1);
         end
         row = DIR_TAB[i];
         x = row.echo ? m_req[m_rcount] : row.rx;
         advance_master(row.op, row.slave, row.regaddr, x);
         if (row.typed) begin
            if (row.t_end)
               pending_out.push_back('{1'b0, 8'h00, 1'b0, 1'b1, row.t_status, row.t_value});
         end else begin
            foreach (step_out[k])
               pending_out.push_back(step_out[k]);
         end
         drive_item(row.op, row.slave, row.regaddr, x);
      end

      target = 0;
      for (int p = 0; p < 5; p++) begin
         settle();
         write_timeout(p == 4 ? 8'($urandom_range(1, 254)) : TMO_PLAN[p]);
         gaps_on = (p != 2);
         stall_on = (p != 2);
         target += PHASE_ITEMS;
         while (live_items < target)
            run_transaction();
      end

      settle();
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
